>>> hw/rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types, constants and helpers of the phong fragment shader pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

   // fixed-point constants
   localparam int Q14_ONE     = 16384;
   localparam int AMBIENT_Q14 = 4915;
   localparam int ALPHA_LIMIT = 200;

   // normaliser geometry
   localparam int NORM_IN_W       = 32;
   localparam int NORM_SQ_STEPS   = 31;
   localparam int NORM_DIV_STEPS  = 15;
   localparam int NORM_LAT        = 5 + NORM_SQ_STEPS + NORM_DIV_STEPS + 1;

   // world position recovery geometry
   localparam int WORLD_DIV_STEPS = 22;
   localparam int WORLD_LAT       = 1 + WORLD_DIV_STEPS + 2;

   // configuration register indexes
   localparam logic [1:0] CSR_LIGHT_DIR  = 2'd0;
   localparam logic [1:0] CSR_CAMERA_POS = 2'd1;
   localparam logic [1:0] CSR_ALPHA_TEST = 2'd2;

   typedef logic signed [15:0]          q14_type;
   typedef logic signed [NORM_IN_W-1:0] norm_in_type;
   typedef logic signed [20:0]          pos_type;

   localparam pos_type POS_MAX = 21'sh0FFFFF;
   localparam pos_type POS_MIN = 21'sh100000;

   // normal-map byte to [-1,1] in Q2.14, truncated toward zero
   // 16384/255 = 64 + 64/255, and y/255 for small y is (y + y>>8 + 1) >> 8
   function automatic q14_type map_comp(input logic [7:0] b);
      logic signed [9:0] n;
      logic [7:0]        a;
      logic [13:0]       y;
      logic [14:0]       f;
      logic [15:0]       m;
      n = $signed({1'b0, b, 1'b0}) - 10'sd255;
      a = n[9] ? 8'(-n) : 8'(n);
      y = {a, 6'b0};
      f = (15'(y) + 15'(y >> 8) + 15'd1) >> 8;
      m = 16'(y) + 16'(f);
      return n[9] ? -$signed(m) : $signed(m);
   endfunction

   // signed division by 2^14, truncated toward zero
   function automatic logic signed [39:0] sdiv14(input logic signed [39:0] v);
      logic [39:0] a;
      a = v[39] ? 40'(-v) : 40'(v);
      a = a >> 14;
      return v[39] ? -$signed(a) : $signed(a);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pfs_norm.sv
// ----------------------------------------------------------------------------
// pfs_norm
// Pipelined vector normaliser: scales a 3-vector so its largest magnitude has
// 22 bits, takes an integer square root of the squared length and divides
// each component by it, giving a unit vector in Q2.14.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_norm (
   input  logic                  clock,
   input  pfs_pkg::norm_in_type  c_in  [3],
   output pfs_pkg::q14_type      n_out [3]
);
   import pfs_pkg::*;

   localparam int SQ = NORM_SQ_STEPS;
   localparam int DV = NORM_DIV_STEPS;
   localparam int CY = 3 + SQ + DV;

   logic [NORM_IN_W-1:0] mag_in [3];
   logic [NORM_IN_W-1:0] mag1_ff [3];
   logic                 neg1_ff [3];
   logic [NORM_IN_W-1:0] or1_ff;
   logic [NORM_IN_W-1:0] mag2_ff [3];
   logic                 neg2_ff [3];
   logic [5:0]           blen_in;
   logic [5:0]           blen_ff;
   logic [21:0]          c3_in [3];
   logic [21:0]          cyc_ff [CY][3];
   logic                 cyn_ff [CY][3];
   logic                 cyz_ff [CY];
   logic [43:0]          sq_ff [3];
   logic [61:0]          x5_ff;
   logic [61:0]          sx_ff [SQ];
   logic [61:0]          sr_ff [SQ];
   logic [30:0]          ds_ff [DV];
   logic [31:0]          dr_ff [DV][3];
   logic [DV-1:0]        dq_ff [DV][3];
   q14_type              out_ff [3];

   // magnitudes of the inputs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = c_in[i][NORM_IN_W-1] ? NORM_IN_W'(-c_in[i]) : NORM_IN_W'(c_in[i]);
      end
   end

   // bit length of the largest magnitude
   always_comb begin
      blen_in = '0;
      for (int b = 0; b < NORM_IN_W; b++) begin
         if (or1_ff[b]) blen_in = 6'(b + 1);
      end
   end

   // rescale so the largest magnitude lies in [2^21, 2^22)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (blen_ff > 6'd22) begin
            c3_in[i] = 22'(mag2_ff[i] >> (blen_ff - 6'd22));
         end else begin
            c3_in[i] = 22'(mag2_ff[i] << (6'd22 - blen_ff));
         end
      end
   end

   // front stages: magnitude, bit length, rescale, squares, length
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= mag_in[i];
         neg1_ff[i] <= c_in[i][NORM_IN_W-1];
         mag2_ff[i] <= mag1_ff[i];
         neg2_ff[i] <= neg1_ff[i];
         cyc_ff[0][i] <= c3_in[i];
         cyn_ff[0][i] <= neg2_ff[i];
         sq_ff[i] <= 44'(cyc_ff[0][i]) * 44'(cyc_ff[0][i]);
      end
      or1_ff  <= mag_in[0] | mag_in[1] | mag_in[2];
      blen_ff <= blen_in;
      cyz_ff[0] <= (blen_ff == 6'd0);
      x5_ff <= {46'(sq_ff[0]) + 46'(sq_ff[1]) + 46'(sq_ff[2]), 16'h0};
      for (int j = 1; j < CY; j++) begin
         cyc_ff[j] <= cyc_ff[j-1];
         cyn_ff[j] <= cyn_ff[j-1];
         cyz_ff[j] <= cyz_ff[j-1];
      end
   end

   // square root, one result bit per stage
   always_ff @(posedge clock) begin
      logic [61:0] x;
      logic [61:0] r;
      logic [61:0] bit_v;
      logic [61:0] t;
      for (int k = 0; k < SQ; k++) begin
         x = (k == 0) ? x5_ff : sx_ff[(k == 0) ? 0 : k-1];
         r = (k == 0) ? 62'd0 : sr_ff[(k == 0) ? 0 : k-1];
         bit_v = 62'd1 << (60 - 2 * k);
         t = r + bit_v;
         if (x >= t) begin
            sx_ff[k] <= x - t;
            sr_ff[k] <= (r >> 1) + bit_v;
         end else begin
            sx_ff[k] <= x;
            sr_ff[k] <= r >> 1;
         end
      end
   end

   // restoring division of component * 2^22 by the root, one bit per stage
   always_ff @(posedge clock) begin
      logic [30:0]   s;
      logic [31:0]   rem;
      logic [31:0]   t;
      logic [DV-1:0] q;
      for (int d = 0; d < DV; d++) begin
         s = (d == 0) ? sr_ff[SQ-1][30:0] : ds_ff[(d == 0) ? 0 : d-1];
         ds_ff[d] <= s;
         for (int i = 0; i < 3; i++) begin
            rem = (d == 0) ? {3'b0, cyc_ff[2+SQ][i], 7'b0} : dr_ff[(d == 0) ? 0 : d-1][i];
            q   = (d == 0) ? '0 : dq_ff[(d == 0) ? 0 : d-1][i];
            t   = {rem[30:0], 1'b0};
            if (t >= {1'b0, s}) begin
               dr_ff[d][i] <= t - {1'b0, s};
               dq_ff[d][i] <= {q[DV-2:0], 1'b1};
            end else begin
               dr_ff[d][i] <= t;
               dq_ff[d][i] <= {q[DV-2:0], 1'b0};
            end
         end
      end
   end

   // sign, zero vector
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cyz_ff[CY-1]) begin
            out_ff[i] <= '0;
         end else if (cyn_ff[CY-1][i]) begin
            out_ff[i] <= -$signed(16'(dq_ff[DV-1][i]));
         end else begin
            out_ff[i] <= $signed(16'(dq_ff[DV-1][i]));
         end
      end
   end

   assign n_out = out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pfs_world.sv
// ----------------------------------------------------------------------------
// pfs_world
// Recovers the world position by dividing by inverse w, saturating to the
// 21-bit range, and forms the view vector camera minus world.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_world (
   input  logic                  clock,
   input  logic [31:0]           inverse_w,
   input  logic [62:0]           scaled_pos,
   input  logic [62:0]           camera_pos,
   output pfs_pkg::norm_in_type  view [3]
);
   import pfs_pkg::*;

   localparam int QW = WORLD_DIV_STEPS;

   pos_type       sp_in [3];
   logic [20:0]   mag_in [3];
   logic [20:0]   mag_ff [3];
   logic          neg_ff [3];
   logic          zero_ff [3];
   logic          ovf_ff [3];
   logic [31:0]   invw_ff;
   logic [31:0]   div_ff [QW];
   logic [31:0]   rem_ff [QW][3];
   logic [QW-1:0] quo_ff [QW][3];
   logic          cneg_ff [QW][3];
   logic          czero_ff [QW][3];
   logic          covf_ff [QW][3];
   pos_type       world_ff [3];
   logic signed [21:0] view_ff [3];

   // unpack and take magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sp_in[i]  = scaled_pos[21*i +: 21];
         mag_in[i] = sp_in[i][20] ? 21'(-sp_in[i]) : 21'(sp_in[i]);
      end
   end

   // quotient of 2^22 or more saturates
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag_ff[i]  <= mag_in[i];
         neg_ff[i]  <= sp_in[i][20];
         zero_ff[i] <= (mag_in[i] == 21'd0);
         ovf_ff[i]  <= ({9'b0, mag_in[i], 2'b0} >= inverse_w);
      end
      invw_ff <= inverse_w;
   end

   // restoring division, one quotient bit per stage
   always_ff @(posedge clock) begin
      logic [31:0]   dv;
      logic [31:0]   rem;
      logic [QW-1:0] q;
      logic [32:0]   t;
      for (int d = 0; d < QW; d++) begin
         dv = (d == 0) ? invw_ff : div_ff[(d == 0) ? 0 : d-1];
         div_ff[d] <= dv;
         for (int i = 0; i < 3; i++) begin
            rem = (d == 0) ? {9'b0, mag_ff[i], 2'b0} : rem_ff[(d == 0) ? 0 : d-1][i];
            q   = (d == 0) ? '0 : quo_ff[(d == 0) ? 0 : d-1][i];
            t   = {rem, 1'b0};
            if (t >= {1'b0, dv}) begin
               rem_ff[d][i] <= 32'(t - {1'b0, dv});
               quo_ff[d][i] <= {q[QW-2:0], 1'b1};
            end else begin
               rem_ff[d][i] <= t[31:0];
               quo_ff[d][i] <= {q[QW-2:0], 1'b0};
            end
            cneg_ff[d][i]  <= (d == 0) ? neg_ff[i]  : cneg_ff[(d == 0) ? 0 : d-1][i];
            czero_ff[d][i] <= (d == 0) ? zero_ff[i] : czero_ff[(d == 0) ? 0 : d-1][i];
            covf_ff[d][i]  <= (d == 0) ? ovf_ff[i]  : covf_ff[(d == 0) ? 0 : d-1][i];
         end
      end
   end

   // saturate to the 21-bit position range, then view vector
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (czero_ff[QW-1][i]) begin
            world_ff[i] <= '0;
         end else if (!cneg_ff[QW-1][i]) begin
            if (covf_ff[QW-1][i] || quo_ff[QW-1][i] > 22'd1048575) world_ff[i] <= POS_MAX;
            else world_ff[i] <= $signed(quo_ff[QW-1][i][20:0]);
         end else begin
            if (covf_ff[QW-1][i] || quo_ff[QW-1][i] > 22'd1048576) world_ff[i] <= POS_MIN;
            else world_ff[i] <= -$signed(quo_ff[QW-1][i][20:0]);
         end
         view_ff[i] <= 22'($signed(camera_pos[21*i +: 21])) - 22'(world_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) view[i] = NORM_IN_W'(view_ff[i]);
   end

endmodule

`default_nettype wire

>>> hw/rtl/phong_fragment_shade.sv
// ----------------------------------------------------------------------------
// phong_fragment_shade
// Per-fragment phong shading with tangent-space normal mapping, fully
// pipelined in fixed point.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: drive the req_ fields and raise start for one cycle per
//   item; an item is taken at each edge with start high and busy low. busy
//   is always low, so one item may enter in every clock cycle.
//   Result channel: each item leaves at the end of the pipeline, with
//   rsp_valid high for one cycle alongside the shaded bytes, the discard
//   flag and the mapped normal. Results come in the order items went in.
//   The path to the result runs through the chain of three normalisers
//   (tangent frame, mapped normal, reflection vector; square root and
//   divide, one bit per stage), plus the rotation, dot-product, lighting
//   and colour stages. The world-position divider and view normaliser run
//   alongside. Throughput is one item per cycle; the receiver cannot hold
//   results off and none is needed since nothing stalls.
//   Configuration: csr_ writes are always accepted (csr_ready high) and
//   should be made while no item is in flight.
//   Reset clears the configuration registers and the valid pipeline; items
//   in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module phong_fragment_shade (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_inverse_w,
   input  logic [62:0] req_scaled_world_position,
   input  logic [47:0] req_interp_normal,
   input  logic [47:0] req_interp_tangent,
   input  logic [47:0] req_interp_bitangent,
   input  logic [31:0] req_diffuse_texel,
   input  logic [23:0] req_normal_texel,
   input  logic [7:0]  req_specular_texel,
   input  logic [8:0]  req_shadow_fraction,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte0,
   output logic [7:0]  rsp_out_byte1,
   output logic [7:0]  rsp_out_byte2,
   output logic        rsp_discard,
   output logic [47:0] rsp_final_normal,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [62:0] csr_wdata
);
   import pfs_pkg::*;

   // stage numbers, counted from the input register
   localparam int ST_IN   = 1;
   localparam int ST_NRM  = ST_IN + NORM_LAT;
   localparam int ST_CMB  = ST_NRM + 2;
   localparam int ST_FN   = ST_CMB + NORM_LAT;
   localparam int ST_DNL  = ST_FN + 2;
   localparam int ST_R    = ST_DNL + 2;
   localparam int ST_RN   = ST_R + NORM_LAT;
   localparam int ST_VN   = ST_IN + WORLD_LAT + NORM_LAT;
   localparam int ST_X    = ST_RN + 2;
   localparam int ST_X10  = ST_X + 4;
   localparam int ST_SPEC = ST_X10 + 4;
   localparam int ST_TOT  = ST_SPEC + 1;
   localparam int ST_OUT  = ST_TOT + 2;

   localparam int MAP_DLY  = ST_NRM - ST_IN;
   localparam int FN_DLY   = ST_OUT - 1 - ST_FN;
   localparam int VN_DLY   = ST_RN - ST_VN;
   localparam int DIFF_DLY = ST_SPEC - ST_DNL;
   localparam int SIDE_LEN = ST_OUT - 2;

   typedef struct packed {
      logic [31:0] diffuse;
      logic [7:0]  spec_tex;
      logic [8:0]  shadow;
      logic        discard;
   } side_type;

   // configuration registers
   logic [47:0] light_ff;
   logic [62:0] camera_ff;
   logic        alpha_en_ff;

   // valid pipeline and input register
   logic        vld_ff [ST_OUT];
   logic [31:0] invw_ff;
   logic [62:0] swp_ff;
   logic [47:0] nrm_ff;
   logic [47:0] tan_ff;
   logic [47:0] btn_ff;
   logic [23:0] ntx_ff;
   side_type    side_in;
   side_type    side_ff [SIDE_LEN];
   side_type    side1_ff;

   norm_in_type nrm_in [3];
   norm_in_type tan_in [3];
   norm_in_type btn_in [3];
   norm_in_type lgt_in [3];
   norm_in_type view   [3];
   q14_type     nn [3];
   q14_type     tn [3];
   q14_type     bn [3];
   q14_type     ln [3];
   q14_type     vn [3];
   q14_type     fn [3];
   q14_type     rn [3];

   q14_type     map_in [3];
   q14_type     map_ff [MAP_DLY][3];
   logic signed [31:0] cp_ff [3][3];
   norm_in_type comb_ff [3];
   q14_type     fnl_ff [FN_DLY][3];
   q14_type     vnl_ff [VN_DLY][3];

   logic signed [31:0] dp_ff [3];
   logic signed [39:0] dsum;
   logic signed [17:0] dnl_ff;
   logic signed [34:0] rp_ff [3];
   logic [16:0]        diff_ff [DIFF_DLY];
   norm_in_type        r_ff [3];
   logic signed [31:0] xp_ff [3];
   logic signed [39:0] xsum;
   logic [14:0]        x_ff;
   logic [14:0]        x2_ff;
   logic [14:0]        x2a_ff;
   logic [14:0]        x2b_ff;
   logic [14:0]        x4_ff;
   logic [14:0]        x8_ff;
   logic [14:0]        x10_ff;
   logic [22:0]        p1_ff;
   logic [31:0]        p2_ff;
   logic [23:0]        y_ff;
   logic [16:0]        q0_ff;
   logic [23:0]        yr;
   logic [16:0]        spec_ff;
   logic [17:0]        total_ff;
   logic [25:0]        cprod_ff [3];
   logic [7:0]         byte_ff [3];
   logic               disc_ff;
   logic [47:0]        fnorm_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff    <= '0;
         camera_ff   <= '0;
         alpha_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIGHT_DIR:  light_ff    <= csr_wdata[47:0];
            CSR_CAMERA_POS: camera_ff   <= csr_wdata;
            CSR_ALPHA_TEST: alpha_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // valid bits travel with the item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ST_OUT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int k = 1; k < ST_OUT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // input register and side data
   always_comb begin
      side_in.diffuse  = req_diffuse_texel;
      side_in.spec_tex = req_specular_texel;
      side_in.shadow   = (req_shadow_fraction > 9'd256) ? 9'd256 : req_shadow_fraction;
      side_in.discard  = alpha_en_ff && (req_diffuse_texel[31:24] < 8'(ALPHA_LIMIT));
   end

   always_ff @(posedge clock) begin
      invw_ff  <= req_inverse_w;
      swp_ff   <= req_scaled_world_position;
      nrm_ff   <= req_interp_normal;
      tan_ff   <= req_interp_tangent;
      btn_ff   <= req_interp_bitangent;
      ntx_ff   <= req_normal_texel;
      side1_ff <= side_in;
      side_ff[0] <= side1_ff;
      for (int k = 1; k < SIDE_LEN; k++) side_ff[k] <= side_ff[k-1];
   end

   // unpack vectors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = NORM_IN_W'($signed(nrm_ff[16*i +: 16]));
         tan_in[i] = NORM_IN_W'($signed(tan_ff[16*i +: 16]));
         btn_in[i] = NORM_IN_W'($signed(btn_ff[16*i +: 16]));
         lgt_in[i] = NORM_IN_W'($signed(light_ff[16*i +: 16]));
      end
   end

   pfs_world u_world (
      .clock      (clock),
      .inverse_w  (invw_ff),
      .scaled_pos (swp_ff),
      .camera_pos (camera_ff),
      .view       (view)
   );

   pfs_norm u_norm_n (.clock(clock), .c_in(nrm_in),  .n_out(nn));
   pfs_norm u_norm_t (.clock(clock), .c_in(tan_in),  .n_out(tn));
   pfs_norm u_norm_b (.clock(clock), .c_in(btn_in),  .n_out(bn));
   pfs_norm u_norm_l (.clock(clock), .c_in(lgt_in),  .n_out(ln));
   pfs_norm u_norm_v (.clock(clock), .c_in(view),    .n_out(vn));
   pfs_norm u_norm_f (.clock(clock), .c_in(comb_ff), .n_out(fn));
   pfs_norm u_norm_r (.clock(clock), .c_in(r_ff),    .n_out(rn));

   // mapped normal components, red byte drives the tangent
   always_comb begin
      map_in[0] = map_comp(ntx_ff[23:16]);
      map_in[1] = map_comp(ntx_ff[15:8]);
      map_in[2] = map_comp(ntx_ff[7:0]);
   end

   // tangent-space rotation of the mapped normal
   always_ff @(posedge clock) begin
      map_ff[0] <= map_in;
      for (int k = 1; k < MAP_DLY; k++) map_ff[k] <= map_ff[k-1];
      for (int i = 0; i < 3; i++) begin
         cp_ff[i][0] <= 32'(tn[i]) * 32'(map_ff[MAP_DLY-1][0]);
         cp_ff[i][1] <= 32'(bn[i]) * 32'(map_ff[MAP_DLY-1][1]);
         cp_ff[i][2] <= 32'(nn[i]) * 32'(map_ff[MAP_DLY-1][2]);
         comb_ff[i]  <= cp_ff[i][0] + cp_ff[i][1] + cp_ff[i][2];
      end
   end

   // delay lines for the final and view normals
   always_ff @(posedge clock) begin
      fnl_ff[0] <= fn;
      for (int k = 1; k < FN_DLY; k++) fnl_ff[k] <= fnl_ff[k-1];
      vnl_ff[0] <= vn;
      for (int k = 1; k < VN_DLY; k++) vnl_ff[k] <= vnl_ff[k-1];
   end

   // n dot l, diffuse term and reflection vector
   assign dsum = 40'(dp_ff[0]) + 40'(dp_ff[1]) + 40'(dp_ff[2]);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dp_ff[i] <= 32'(fn[i]) * 32'(ln[i]);
         rp_ff[i] <= (35'(fnl_ff[1][i]) * 35'(dnl_ff)) <<< 1;
         r_ff[i]  <= NORM_IN_W'(sdiv14(40'(rp_ff[i]))) - NORM_IN_W'(ln[i]);
      end
      dnl_ff <= 18'(sdiv14(dsum));
      if (dnl_ff > 18'sd0) begin
         diff_ff[0] <= 17'((26'(dnl_ff[16:0]) * 26'(side_ff[ST_DNL-2].shadow)) >> 8);
      end else begin
         diff_ff[0] <= '0;
      end
      for (int k = 1; k < DIFF_DLY; k++) diff_ff[k] <= diff_ff[k-1];
   end

   // r dot v, clamped to [0, 1], and the tenth power
   assign xsum = 40'(xp_ff[0]) + 40'(xp_ff[1]) + 40'(xp_ff[2]);

   always_ff @(posedge clock) begin
      logic signed [39:0] xs;
      for (int i = 0; i < 3; i++) xp_ff[i] <= 32'(rn[i]) * 32'(vnl_ff[VN_DLY-1][i]);
      xs = sdiv14(xsum);
      if (xs < 40'sd0) x_ff <= '0;
      else if (xs > 40'sd16384) x_ff <= 15'd16384;
      else x_ff <= xs[14:0];
      x2_ff  <= 15'((30'(x_ff) * 30'(x_ff)) >> 14);
      x2a_ff <= x2_ff;
      x4_ff  <= 15'((30'(x2_ff) * 30'(x2_ff)) >> 14);
      x2b_ff <= x2a_ff;
      x8_ff  <= 15'((30'(x4_ff) * 30'(x4_ff)) >> 14);
      x10_ff <= 15'((30'(x8_ff) * 30'(x2b_ff)) >> 14);
   end

   // specular: x10 * gloss * shadow / 65280, the /255 by reciprocal
   assign yr = y_ff - 24'({q0_ff, 8'b0} - 25'(q0_ff));

   always_ff @(posedge clock) begin
      p1_ff   <= 23'(x10_ff) * 23'(side_ff[ST_X10-2].spec_tex);
      p2_ff   <= 32'(p1_ff) * 32'(side_ff[ST_X10-1].shadow);
      y_ff    <= p2_ff[31:8];
      q0_ff   <= 17'((40'(p2_ff[31:8]) * 40'd32896) >> 23);
      spec_ff <= (yr >= 24'd255) ? q0_ff + 17'd1 : q0_ff;
   end

   // total intensity and saturated colour bytes
   always_ff @(posedge clock) begin
      total_ff <= 18'(AMBIENT_Q14) + 18'(diff_ff[DIFF_DLY-1]) + 18'(spec_ff);
      for (int i = 0; i < 3; i++) begin
         cprod_ff[i] <= 26'(side_ff[ST_TOT-2].diffuse[8*i +: 8]) * 26'(total_ff);
         byte_ff[i]  <= (cprod_ff[i][25:14] > 12'd255) ? 8'd255 : cprod_ff[i][21:14];
      end
      disc_ff  <= side_ff[ST_OUT-3].discard;
      fnorm_ff <= {fnl_ff[FN_DLY-1][2], fnl_ff[FN_DLY-1][1], fnl_ff[FN_DLY-1][0]};
   end

   assign rsp_valid        = vld_ff[ST_OUT-1];
   assign rsp_out_byte0    = byte_ff[0];
   assign rsp_out_byte1    = byte_ff[1];
   assign rsp_out_byte2    = byte_ff[2];
   assign rsp_discard      = disc_ff;
   assign rsp_final_normal = fnorm_ff;

endmodule

`default_nettype wire
